// ===== rtl/tiv_pkg.sv =====
`default_nettype none
package tiv_pkg;

  localparam int TIME_W    = 32;
  localparam int RAND_W    = 32;
  localparam int OUT_W     = 32;
  localparam int MIN_W     = 16;
  localparam int DBL_W     = 5;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int SH_W      = MIN_W + (2 ** DBL_W) - 1;
  localparam int EXT_W     = SH_W + TIME_W;
  localparam int CNT_W     = $clog2(RAND_W + 1);

  localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(1000);
  localparam logic [DBL_W-1:0] DBL_RESET = DBL_W'(8);

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DOUBLINGS = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_RESET = 2'd2,
    ACT_STOP  = 2'd3
  } tiv_action_t;

  typedef struct packed {
    logic load_in;
    logic start_draw_i;
    logic set_min;
    logic stop;
    logic tick;
    logic dbl;
    logic start_draw_s;
    logic use_swap;
    logic commit_i;
    logic commit_s;
    logic load_out;
  } tiv_cmd_t;

  typedef struct packed {
    tiv_action_t action;
    logic        running;
    logic        tick_wrap;
    logic        mod_busy;
    logic        mod_done;
  } tiv_sts_t;

endpackage
`default_nettype wire

// ===== rtl/tiv_mod_unit.sv =====
`default_nettype none
module tiv_mod_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tiv_pkg::RAND_W-1:0]  dividend,
  input  wire logic [tiv_pkg::TIME_W-1:0]  divisor,
  output logic                             busy,
  output logic                             done,
  output logic [tiv_pkg::TIME_W-1:0]       remainder
);
  import tiv_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RAND_W-1:0] div_r, div_nxt;
  logic [TIME_W-1:0] dsr_r, dsr_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;

  // one quotient bit per cycle, restoring form
  assign shifted = {rem_r, div_r[RAND_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(RAND_W);
      div_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      div_nxt = {div_r[RAND_W-2:0], 1'b0};
      rem_nxt = (shifted >= {1'b0, dsr_r}) ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r <= div_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("remainder unit not busy after start");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("done without a finished run");

endmodule
`default_nettype wire

// ===== rtl/tiv_datapath.sv =====
`default_nettype none
module tiv_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [tiv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tiv_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic [1:0]                     in_action,
  input  wire logic [tiv_pkg::RAND_W-1:0]     in_random_word,
  input  wire tiv_pkg::tiv_cmd_t              cmd,
  output tiv_pkg::tiv_sts_t                   sts,
  output logic                                out_send_advert,
  output logic [tiv_pkg::OUT_W-1:0]           out_interval_now,
  output logic                                out_is_running
);
  import tiv_pkg::*;

  logic [MIN_W-1:0]  imin_r;
  logic [DBL_W-1:0]  max_dbl_r;
  tiv_action_t       action_r;
  logic [RAND_W-1:0] rand_r;
  logic              running_r;
  logic [TIME_W-1:0] interval_r;
  logic [TIME_W-1:0] send_time_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [TIME_W-1:0] lo_r;
  logic              send_r;
  logic              o_send_r;
  logic [OUT_W-1:0]  o_interval_r;
  logic              o_running_r;

  logic [MIN_W-1:0]        min_fix;
  logic [TIME_W-1:0]       eff_min;
  logic [EXT_W-1:0]        max_shift;
  logic [TIME_W-1:0]       eff_max;
  logic [TIME_W-1:0]       elapsed_inc;
  logic [TIME_W-1:0]       s_lo, s_hi;
  logic [TIME_W-1:0]       doubled;
  logic [RAND_W-1:0]       swapped;
  logic                    mod_start;
  logic [RAND_W-1:0]       mod_dividend;
  logic [TIME_W-1:0]       mod_divisor;
  logic                    mod_busy, mod_done;
  logic [TIME_W-1:0]       mod_rem;
  logic [OUT_W+TIME_W-1:0] interval_ext;

  assign min_fix   = (imin_r == '0) ? MIN_W'(1) : imin_r;
  assign eff_min   = TIME_W'(min_fix);
  assign max_shift = EXT_W'(min_fix) << max_dbl_r;
  // saturate the maximum at the widest time value
  assign eff_max   = (|max_shift[EXT_W-1:TIME_W]) ? '1 : max_shift[TIME_W-1:0];

  assign elapsed_inc = elapsed_r + TIME_W'(1);

  always_comb begin
    s_lo = interval_r >> 1;
    s_hi = interval_r - TIME_W'(1);
    if (s_lo == '0) s_lo = TIME_W'(1);
    if (s_hi == '0) s_hi = TIME_W'(1);
  end

  assign doubled = (interval_r > (eff_max >> 1)) ? eff_max : (interval_r << 1);
  assign swapped = {rand_r[RAND_W/2-1:0], rand_r[RAND_W-1:RAND_W/2]};

  assign mod_start    = cmd.start_draw_i || cmd.start_draw_s;
  assign mod_dividend = (cmd.start_draw_s && cmd.use_swap) ? swapped : rand_r;
  assign mod_divisor  = cmd.start_draw_i ? (eff_max - eff_min + TIME_W'(1))
                                         : (s_hi - s_lo + TIME_W'(1));

  tiv_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (mod_divisor),
    .busy      (mod_busy),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imin_r      <= MIN_RESET;
      max_dbl_r   <= DBL_RESET;
      running_r   <= 1'b0;
      interval_r  <= '0;
      send_time_r <= '0;
      elapsed_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INTERVAL_MIN:  imin_r    <= cfg_data[MIN_W-1:0];
          CFG_MAX_DOUBLINGS: max_dbl_r <= cfg_data[DBL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start_draw_i) begin
        elapsed_r <= '0;
        running_r <= 1'b1;
      end
      if (cmd.set_min) begin
        interval_r <= eff_min;
        elapsed_r  <= '0;
        running_r  <= 1'b1;
      end
      if (cmd.stop) running_r <= 1'b0;
      if (cmd.tick) elapsed_r <= sts.tick_wrap ? '0 : elapsed_inc;
      if (cmd.dbl) interval_r <= doubled;
      if (cmd.commit_i) interval_r <= lo_r + mod_rem;
      if (cmd.commit_s) send_time_r <= lo_r + mod_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_r <= tiv_action_t'(in_action);
      rand_r   <= in_random_word;
    end
    if (cmd.start_draw_i) lo_r <= eff_min;
    else if (cmd.start_draw_s) lo_r <= s_lo;
    if (cmd.load_in) send_r <= 1'b0;
    else if (cmd.tick) send_r <= (elapsed_inc == send_time_r);
    if (cmd.load_out) begin
      o_send_r     <= send_r;
      o_interval_r <= interval_ext[OUT_W-1:0];
      o_running_r  <= running_r;
    end
  end

  assign interval_ext = {{OUT_W{1'b0}}, interval_r};

  assign sts.action    = action_r;
  assign sts.running   = running_r;
  assign sts.tick_wrap = (elapsed_inc >= interval_r);
  assign sts.mod_busy  = mod_busy;
  assign sts.mod_done  = mod_done;

  assign out_send_advert  = o_send_r;
  assign out_interval_now = o_interval_r;
  assign out_is_running   = o_running_r;

endmodule
`default_nettype wire

// ===== rtl/tiv_ctrl.sv =====
`default_nettype none
module tiv_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire tiv_pkg::tiv_sts_t  sts,
  output tiv_pkg::tiv_cmd_t       cmd
);
  import tiv_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE       = 7'b0000001,
    ST_DECODE     = 7'b0000010,
    ST_WAIT_I     = 7'b0000100,
    ST_DOUBLE     = 7'b0001000,
    ST_SEND_SETUP = 7'b0010000,
    ST_WAIT_S     = 7'b0100000,
    ST_DONE       = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.action)
          ACT_START: begin
            cmd.start_draw_i = 1'b1;
            state_nxt        = ST_WAIT_I;
          end
          ACT_RESET: begin
            cmd.set_min = 1'b1;
            state_nxt   = ST_SEND_SETUP;
          end
          ACT_STOP: begin
            cmd.stop  = 1'b1;
            state_nxt = ST_DONE;
          end
          default: begin
            // tick: ignored while stopped
            if (sts.running) begin
              cmd.tick  = 1'b1;
              state_nxt = sts.tick_wrap ? ST_DOUBLE : ST_DONE;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        endcase
      end
      ST_WAIT_I: begin
        if (sts.mod_done) begin
          cmd.commit_i = 1'b1;
          state_nxt    = ST_SEND_SETUP;
        end
      end
      ST_DOUBLE: begin
        cmd.dbl   = 1'b1;
        state_nxt = ST_SEND_SETUP;
      end
      ST_SEND_SETUP: begin
        cmd.start_draw_s = 1'b1;
        cmd.use_swap     = (sts.action == ACT_START);
        state_nxt        = ST_WAIT_S;
      end
      ST_WAIT_S: begin
        if (sts.mod_done) begin
          cmd.commit_s = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished request not placed in output register");

  a_wait_has_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT_I || state_r == ST_WAIT_S) |-> (sts.mod_busy || sts.mod_done))
    else $error("waiting on a draw that is not running");

endmodule
`default_nettype wire

// ===== rtl/trickle_interval_timer_core.sv =====
`default_nettype none
// Channel  | Handshake                  | Payload
// ---------+----------------------------+--------------------------------------------------
// input    | in_valid / in_ready        | in_action[1:0], in_random_word[31:0]
// result   | out_valid / out_ready      | out_send_advert, out_interval_now[31:0],
//          |                            | out_is_running
// config   | cfg_we (no wait)           | cfg_index[0], cfg_data[15:0]
//
// One request at a time. Stop and a tick inside the interval need no draw; a tick that
// ends it doubles the interval and draws a send time, reset draws a send time, start an
// interval, then a send time. Each random draw runs a bit-serial remainder unit, one bit
// of the 32-bit word per cycle. Reset is synchronous and active low; timer state clears,
// registers return to an interval minimum of 1000 and 8 doublings. A finished result
// waits in the output register while out_ready is low; the next request is taken then.
module trickle_interval_timer_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_action,
  input  wire logic [tiv_pkg::RAND_W-1:0]     in_random_word,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_send_advert,
  output logic [tiv_pkg::OUT_W-1:0]           out_interval_now,
  output logic                                out_is_running,
  input  wire logic                           cfg_we,
  input  wire logic [tiv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tiv_pkg::CFG_W-1:0]      cfg_data
);
  import tiv_pkg::*;

  tiv_cmd_t cmd;
  tiv_sts_t sts;

  tiv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tiv_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_action        (in_action),
    .in_random_word   (in_random_word),
    .cmd              (cmd),
    .sts              (sts),
    .out_send_advert  (out_send_advert),
    .out_interval_now (out_interval_now),
    .out_is_running   (out_is_running)
  );

endmodule
`default_nettype wire
